// ----- rtl/stcp_pkg.sv -----
// types, constants and the line time function of the serial time command parser
// no dependencies; imported by every module of the block
`default_nettype none

package stcp_pkg;

    localparam int CHAR_W     = 8;
    localparam int EVENT_W    = 2;
    localparam int DIGIT_W    = 4;
    localparam int TIME_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int NUM_LINES  = 2;
    localparam int LINE_DIGITS = 5;
    localparam int POS_W      = 3;

    // event codes
    localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EVENT_W-1:0] EV_START = 2'd1;
    localparam logic [EVENT_W-1:0] EV_WAIT  = 2'd2;
    localparam logic [EVENT_W-1:0] EV_SHOW  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEWLINE = 8'd3;

    // reset values of the command characters
    localparam logic [CHAR_W-1:0] START_RST   = 8'd115;
    localparam logic [CHAR_W-1:0] WAIT_RST    = 8'd119;
    localparam logic [CHAR_W-1:0] END_RST     = 8'd101;
    localparam logic [CHAR_W-1:0] NEWLINE_RST = 8'd10;

    // fixed characters
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_ONE   = 8'd49;
    localparam logic [CHAR_W-1:0] CHAR_TWO   = 8'd50;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

    localparam logic [POS_W-1:0] POS_LAST = 3'd4;

    // digit weights
    localparam logic [TIME_W-1:0] WEIGHT_0 = 16'd6000;
    localparam logic [TIME_W-1:0] WEIGHT_1 = 16'd1000;
    localparam logic [TIME_W-1:0] WEIGHT_2 = 16'd100;
    localparam logic [TIME_W-1:0] WEIGHT_3 = 16'd10;
    localparam logic [TIME_W-1:0] TIME_MAX = 16'd63999;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef digit_t [LINE_DIGITS-1:0] digit_row_t;

    typedef struct packed {
        logic [CHAR_W-1:0] start_char;
        logic [CHAR_W-1:0] wait_char;
        logic [CHAR_W-1:0] end_char;
        logic [CHAR_W-1:0] newline_char;
    } stcp_cfg_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic               line_index;
        logic [TIME_W-1:0]  time_value;
    } stcp_result_t;

    function automatic logic [TIME_W-1:0] line_time(input digit_row_t row);
        logic [TIME_W-1:0] sum;
        sum = TIME_W'(row[0]) * WEIGHT_0
            + TIME_W'(row[1]) * WEIGHT_1
            + TIME_W'(row[2]) * WEIGHT_2
            + TIME_W'(row[3]) * WEIGHT_3
            + TIME_W'(row[4]);
        return sum;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/stcp_cfg_regs.sv -----
// command character registers of the serial time command parser
// depends on stcp_pkg
`default_nettype none

module stcp_cfg_regs
    import stcp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [CHAR_W-1:0]    wr_data,
    output stcp_cfg_t                 cfg
);

    stcp_cfg_t cfg_reg;
    stcp_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_START:   cfg_next.start_char   = wr_data;
                REG_WAIT:    cfg_next.wait_char    = wr_data;
                REG_END:     cfg_next.end_char     = wr_data;
                REG_NEWLINE: cfg_next.newline_char = wr_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_char   <= START_RST;
            cfg_reg.wait_char    <= WAIT_RST;
            cfg_reg.end_char     <= END_RST;
            cfg_reg.newline_char <= NEWLINE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/stcp_parser.sv -----
// parse state, stored digits and per-character decode of the time command parser
// depends on stcp_pkg
`default_nettype none

module stcp_parser
    import stcp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [CHAR_W-1:0] rx_char,
    input  wire stcp_cfg_t         cfg,
    output stcp_result_t           res
);

    typedef enum logic [3:0] {
        PARSE_IDLE     = 4'b0001,
        PARSE_LOCKED   = 4'b0010,
        PARSE_ENTRY    = 4'b0100,
        PARSE_IDLE_END = 4'b1000
    } mode_t;

    mode_t            mode_reg;
    mode_t            mode_next;
    logic             line_reg;
    logic             line_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    digit_row_t       digits_reg [NUM_LINES];

    logic             ready;
    logic             is_term;
    logic             is_digit;
    logic             wr_en;
    logic [POS_W-1:0] wr_pos;
    logic [EVENT_W-1:0] event_code;
    digit_row_t       row_next;

    always_comb
    begin
        ready      = (mode_reg == PARSE_IDLE);
        is_term    = (rx_char == cfg.newline_char) || (rx_char == CHAR_CR);
        is_digit   = rx_char inside {[CHAR_ZERO:CHAR_NINE]};
        wr_pos     = (pos_reg > POS_LAST) ? POS_LAST : pos_reg;
        mode_next  = mode_reg;
        line_next  = line_reg;
        pos_next   = pos_reg;
        wr_en      = 1'b0;
        event_code = EV_NONE;

        if (is_term)
        begin
            mode_next = PARSE_IDLE;
        end
        else if (ready && rx_char == cfg.start_char)
        begin
            mode_next  = PARSE_LOCKED;
            event_code = EV_START;
        end
        else if (ready && rx_char == cfg.wait_char)
        begin
            mode_next  = PARSE_LOCKED;
            event_code = EV_WAIT;
        end
        else if (ready && (rx_char == CHAR_ONE || rx_char == CHAR_TWO))
        begin
            mode_next = PARSE_ENTRY;
            line_next = ~rx_char[0];
            pos_next  = '0;
        end
        else if (mode_reg == PARSE_ENTRY && is_digit)
        begin
            wr_en    = 1'b1;
            pos_next = wr_pos + POS_W'(1);
            if (pos_next > POS_LAST)
            begin
                mode_next  = PARSE_LOCKED;
                event_code = EV_SHOW;
            end
        end
        else if (ready && rx_char == cfg.end_char)
        begin
            mode_next = PARSE_IDLE_END;
        end

        // a digit write only lands on the line already selected
        row_next = digits_reg[line_next];
        if (wr_en)
        begin
            row_next[wr_pos] = rx_char[DIGIT_W-1:0];
        end

        res.event_res  = event_code;
        res.line_index = line_next;
        res.time_value = line_time(row_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= PARSE_IDLE;
            line_reg <= 1'b0;
            pos_reg  <= '0;
            for (int i = 0; i < NUM_LINES; i++)
            begin
                digits_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            pos_reg  <= pos_next;
            if (wr_en)
            begin
                digits_reg[line_reg] <= row_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/serial_time_command_parser_unit.sv -----
// Serial time command parser: takes one received character per cycle and returns one
// result per character, the echo plus event, selected line and that line's time. A request
// passes an input register and then a result register, which presents the result; a new
// character is taken every cycle while the result side keeps up, the rate being set by the
// combinational decode and digit store update. Command characters are written through the
// configuration port while the block is idle: the user's duty, not enforced by the block.
// depends on stcp_pkg, stcp_cfg_regs, stcp_parser
`default_nettype none

module serial_time_command_parser_unit
    import stcp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [CHAR_W-1:0]    rx_char,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [CHAR_W-1:0]         echo_char,
    output logic [EVENT_W-1:0]        event_res,
    output logic                      line_index,
    output logic [TIME_W-1:0]         time_value,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CHAR_W-1:0]    cfg_data
);

    stcp_cfg_t         cfg;
    stcp_result_t      res;
    stcp_result_t      out_res_reg;
    logic              s1_valid_reg;
    logic [CHAR_W-1:0] s1_char_reg;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              advance;
    logic              step;

    assign cfg_ready = 1'b1;

    stcp_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    stcp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_char (s1_char_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // result register frees up when empty or taken this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_char_reg <= rx_char;
        end
        if (step)
        begin
            out_char_reg <= s1_char_reg;
            out_res_reg  <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign echo_char  = out_char_reg;
    assign event_res  = out_res_reg.event_res;
    assign line_index = out_res_reg.line_index;
    assign time_value = out_res_reg.time_value;

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> time_value <= TIME_MAX)
        else $error("time value out of range");

    a_show_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_SHOW |-> echo_char >= CHAR_ZERO && echo_char <= CHAR_NINE)
        else $error("show event on a non-digit");

    a_start_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_START |-> echo_char == cfg.start_char)
        else $error("start event on the wrong character");

    a_wait_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_WAIT |-> echo_char == cfg.wait_char)
        else $error("wait event on the wrong character");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
